>>> sv/lsdrs_pkg.sv
// Package for the LSD radix sort unit: constants, defaults and the command struct.
// Used by lsdrs_ctrl, lsdrs_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package lsdrs_pkg;

	localparam int MAX_ITEMS_DEF    = 64;
	localparam int BUCKET_COUNT_DEF = 256;
	localparam int KEY_W            = 32;
	localparam int INDEX_W          = 6;
	localparam int DIGIT_W          = 8;
	localparam logic [1:0] LAST_PASS = 2'd3;

	// one-hot-ish datapath commands, driven from controller state
	typedef struct packed {
		logic load_wr;   // store incoming key at load count
		logic list_init; // list head to element 0
		logic item_rd;   // read key/link at list pointer
		logic dig_cap;   // take digit, read bucket tail
		logic append;    // append element to its bucket
		logic bkt_rd;    // read head/tail of scan bucket
		logic bkt_link;  // chain scan bucket into new list
		logic out_cap;   // load result registers, step pointer
	} cmd_t;

endpackage

>>> sv/lsdrs_datapath.sv
// Datapath of the LSD radix sort unit: key, link, bucket head/tail memories,
// bucket used bits, list pointer and result registers. Depends on lsdrs_pkg.
`timescale 1ns / 1ps

module lsdrs_datapath #(
	parameter int MAX_ITEMS    = lsdrs_pkg::MAX_ITEMS_DEF,
	parameter int BUCKET_COUNT = lsdrs_pkg::BUCKET_COUNT_DEF,
	localparam int IW = $clog2(MAX_ITEMS),
	localparam int CW = $clog2(MAX_ITEMS + 1),
	localparam int BW = $clog2(BUCKET_COUNT)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lsdrs_pkg::cmd_t                   cmd,
	input  logic [CW-1:0]                     load_cnt,
	input  logic [BW-1:0]                     bkt,
	input  logic [1:0]                        pass,
	input  logic [lsdrs_pkg::KEY_W-1:0]       sort_key,
	output logic                              bkt_used,
	output logic [lsdrs_pkg::INDEX_W-1:0]     item_index,
	output logic [lsdrs_pkg::KEY_W-1:0]       sorted_key
);

	logic [lsdrs_pkg::KEY_W-1:0] key_mem [MAX_ITEMS];
	logic [IW-1:0]               link_mem [MAX_ITEMS];
	logic [IW-1:0]               head_mem [BUCKET_COUNT];
	logic [IW-1:0]               tail_mem [BUCKET_COUNT];
	logic [BUCKET_COUNT-1:0]     used_q;

	logic [lsdrs_pkg::KEY_W-1:0] key_rd_q;
	logic [IW-1:0]               link_rd_q;
	logic [IW-1:0]               head_rd_q;
	logic [IW-1:0]               tail_rd_q;
	logic [IW-1:0]               cur_q;
	logic [IW-1:0]               idx_q;
	logic [IW-1:0]               nxt_q;
	logic [BW-1:0]               dig_q;
	logic [IW-1:0]               out_idx_q;
	logic [lsdrs_pkg::KEY_W-1:0] out_key_q;

	logic [lsdrs_pkg::DIGIT_W-1:0] byte_val;
	logic [BW-1:0]                 dig;
	logic [BW-1:0]                 tail_addr;
	logic [IW-1:0]                 load_addr;

	assign load_addr = load_cnt[IW-1:0];
	assign byte_val  = key_rd_q[pass * lsdrs_pkg::DIGIT_W +: lsdrs_pkg::DIGIT_W];

	// digits past the top bucket saturate
	always_comb begin
		if ({1'b0, byte_val} >= 9'(BUCKET_COUNT)) begin
			dig = BW'(BUCKET_COUNT - 1);
		end else begin
			dig = BW'(byte_val);
		end
	end

	assign tail_addr = cmd.dig_cap ? dig : bkt;
	assign bkt_used  = used_q[bkt];

	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			key_mem[load_addr] <= sort_key;
		end
		if (cmd.item_rd) begin
			key_rd_q <= key_mem[cur_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			link_mem[load_addr] <= IW'(load_cnt + 1'b1);
		end else if (cmd.append && used_q[dig_q]) begin
			link_mem[tail_rd_q] <= idx_q;
		end else if (cmd.bkt_link) begin
			link_mem[tail_rd_q] <= cur_q;
		end
		if (cmd.item_rd) begin
			link_rd_q <= link_mem[cur_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.append && !used_q[dig_q]) begin
			head_mem[dig_q] <= idx_q;
		end
		if (cmd.bkt_rd) begin
			head_rd_q <= head_mem[bkt];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			tail_mem[dig_q] <= idx_q;
		end
		if (cmd.dig_cap || cmd.bkt_rd) begin
			tail_rd_q <= tail_mem[tail_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.append) begin
			used_q[dig_q] <= 1'b1;
		end else if (cmd.bkt_link) begin
			used_q[bkt] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.list_init) begin
			cur_q <= '0;
		end else if (cmd.append) begin
			cur_q <= nxt_q;
		end else if (cmd.bkt_link) begin
			cur_q <= head_rd_q;
		end else if (cmd.out_cap) begin
			cur_q <= link_rd_q;
		end
		if (cmd.dig_cap) begin
			dig_q <= dig;
			idx_q <= cur_q;
			nxt_q <= link_rd_q;
		end
		if (cmd.out_cap) begin
			out_idx_q <= cur_q;
			out_key_q <= key_rd_q;
		end
	end

	assign item_index = lsdrs_pkg::INDEX_W'(out_idx_q);
	assign sorted_key = out_key_q;

endmodule

>>> sv/lsdrs_ctrl.sv
// Controller of the LSD radix sort unit: load, distribute, chain and drain
// sequencing, counters and result handshake. Depends on lsdrs_pkg.
`timescale 1ns / 1ps

module lsdrs_ctrl #(
	parameter int MAX_ITEMS    = lsdrs_pkg::MAX_ITEMS_DEF,
	parameter int BUCKET_COUNT = lsdrs_pkg::BUCKET_COUNT_DEF,
	localparam int CW = $clog2(MAX_ITEMS + 1),
	localparam int BW = $clog2(BUCKET_COUNT)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load_valid,
	output logic            load_stall,
	input  logic            last_item,
	output logic            result_valid,
	input  logic            result_stall,
	output logic            end_of_run,
	input  logic            bkt_used,
	output lsdrs_pkg::cmd_t cmd,
	output logic [CW-1:0]   load_cnt,
	output logic [BW-1:0]   bkt,
	output logic [1:0]      pass
);

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_D_RD,
		ST_D_DIG,
		ST_D_APP,
		ST_C_CHK,
		ST_C_WR,
		ST_E_RD,
		ST_E_CAP,
		ST_E_WAIT
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] k_q;
	logic [BW-1:0] b_q;
	logic [1:0]    pass_q;
	logic          out_valid_q;
	logic          end_q;

	logic load_acc;
	logic k_last;

	assign load_acc = load_valid && !load_stall;
	assign k_last   = (k_q == CW'(cnt_q - 1'b1));

	assign load_stall   = (state_q != ST_LOAD);
	assign result_valid = out_valid_q;
	assign end_of_run   = end_q;
	assign load_cnt     = cnt_q;
	assign bkt          = b_q;
	assign pass         = pass_q;

	always_comb begin
		cmd           = '0;
		cmd.load_wr   = load_acc && (cnt_q < CW'(MAX_ITEMS));
		cmd.list_init = load_acc && last_item;
		cmd.item_rd   = (state_q == ST_D_RD) || (state_q == ST_E_RD);
		cmd.dig_cap   = (state_q == ST_D_DIG);
		cmd.append    = (state_q == ST_D_APP);
		cmd.bkt_rd    = (state_q == ST_C_CHK) && bkt_used;
		cmd.bkt_link  = (state_q == ST_C_WR);
		cmd.out_cap   = (state_q == ST_E_CAP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			k_q         <= '0;
			b_q         <= '0;
			pass_q      <= '0;
			out_valid_q <= 1'b0;
			end_q       <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (load_acc) begin
						if (cmd.load_wr) begin
							cnt_q <= cnt_q + 1'b1;
						end
						if (last_item) begin
							k_q     <= '0;
							pass_q  <= '0;
							state_q <= ST_D_RD;
						end
					end
				end
				ST_D_RD: begin
					state_q <= ST_D_DIG;
				end
				ST_D_DIG: begin
					state_q <= ST_D_APP;
				end
				ST_D_APP: begin
					if (k_last) begin
						k_q     <= '0;
						b_q     <= BW'(BUCKET_COUNT - 1);
						state_q <= ST_C_CHK;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_D_RD;
					end
				end
				ST_C_CHK, ST_C_WR: begin
					if (state_q == ST_C_CHK && bkt_used) begin
						state_q <= ST_C_WR;
					end else if (b_q != '0) begin
						b_q     <= b_q - 1'b1;
						state_q <= ST_C_CHK;
					end else if (pass_q == lsdrs_pkg::LAST_PASS) begin
						pass_q  <= '0;
						state_q <= ST_E_RD;
					end else begin
						pass_q  <= pass_q + 1'b1;
						state_q <= ST_D_RD;
					end
				end
				ST_E_RD: begin
					state_q <= ST_E_CAP;
				end
				ST_E_CAP: begin
					out_valid_q <= 1'b1;
					end_q       <= k_last;
					state_q     <= ST_E_WAIT;
				end
				ST_E_WAIT: begin
					if (!result_stall) begin
						out_valid_q <= 1'b0;
						if (end_q) begin
							cnt_q   <= '0;
							k_q     <= '0;
							end_q   <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_E_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ITEMS))
		else $error("load count above capacity");

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> (k_q < cnt_q))
		else $error("element counter ran past loaded count");

	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(load_acc && last_item) |=> (load_stall && !result_valid))
		else $error("last request did not start the sort");

	a_run_done: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && end_of_run) |=> (!load_stall && cnt_q == '0))
		else $error("unit not empty after final result");

	a_valid_only_drain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> load_stall)
		else $error("result offered while loading");
`endif

endmodule

>>> sv/lsd_radix_sort_linked_buckets_unit.sv
// Top level of the LSD radix sort unit (8-bit digits, 32-bit keys, linked buckets).
// Instantiates lsdrs_ctrl and lsdrs_datapath; depends on lsdrs_pkg.
//
//   channel  | handshake                  | payload
//   load     | load_valid / load_stall    | sort_key, last_item
//   result   | result_valid / result_stall| item_index, sorted_key, end_of_run
//
// Keys load one per cycle while load_stall is low. A last request starts four
// passes; each pass reads, digits and appends each key, then chains each non-empty
// bucket. Drain offers one result at a time, held while result_stall is high.
// Reset clears control and bucket used bits; no memory clearing pass.
// load_stall is high from the last request until the final result is taken.
`timescale 1ns / 1ps

module lsd_radix_sort_linked_buckets_unit #(
	parameter int MAX_ITEMS    = lsdrs_pkg::MAX_ITEMS_DEF,
	parameter int BUCKET_COUNT = lsdrs_pkg::BUCKET_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load_valid,
	output logic                          load_stall,
	input  logic [lsdrs_pkg::KEY_W-1:0]   sort_key,
	input  logic                          last_item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [lsdrs_pkg::INDEX_W-1:0] item_index,
	output logic [lsdrs_pkg::KEY_W-1:0]   sorted_key,
	output logic                          end_of_run
);

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int BW = $clog2(BUCKET_COUNT);

	lsdrs_pkg::cmd_t cmd;
	logic [CW-1:0]   load_cnt;
	logic [BW-1:0]   bkt;
	logic [1:0]      pass;
	logic            bkt_used;

	lsdrs_ctrl #(
		.MAX_ITEMS    (MAX_ITEMS),
		.BUCKET_COUNT (BUCKET_COUNT)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_valid   (load_valid),
		.load_stall   (load_stall),
		.last_item    (last_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.end_of_run   (end_of_run),
		.bkt_used     (bkt_used),
		.cmd          (cmd),
		.load_cnt     (load_cnt),
		.bkt          (bkt),
		.pass         (pass)
	);

	lsdrs_datapath #(
		.MAX_ITEMS    (MAX_ITEMS),
		.BUCKET_COUNT (BUCKET_COUNT)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.load_cnt   (load_cnt),
		.bkt        (bkt),
		.pass       (pass),
		.sort_key   (sort_key),
		.bkt_used   (bkt_used),
		.item_index (item_index),
		.sorted_key (sorted_key)
	);

endmodule

>>> tb/sv/lsd_radix_sort_linked_buckets_unit_tb.sv
// Testbench for lsd_radix_sort_linked_buckets_unit: loads key sets, predicts the stable
// ascending order with index and end mark, and checks every sorted result.
// Depends on lsdrs_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module lsd_radix_sort_linked_buckets_unit_tb;

	localparam int QUIET_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam int RAND_ITEMS  = 190;

	typedef struct {
		logic [lsdrs_pkg::INDEX_W-1:0] index;
		logic [lsdrs_pkg::KEY_W-1:0]   key;
		logic                          last;
	} rank_t;

	class rank_board;
		logic [lsdrs_pkg::KEY_W-1:0] held[lsdrs_pkg::MAX_ITEMS_DEF];
		int held_count;
		rank_t pending[$];
		int errors;

		function new();
			held_count = 0;
			errors = 0;
		endfunction

		task report(input string what);
			if (errors < 40)
				$display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		// stable LSD order of the held keys, low byte first
		function void radix_ranks();
			int order[$];
			int next_order[$];
			rank_t r;
			for (int i = 0; i < held_count; i++)
				order.push_back(i);
			for (int p = 0; p < 4; p++) begin
				next_order.delete();
				for (int d = 0; d < (1 << lsdrs_pkg::DIGIT_W); d++)
					foreach (order[i])
						if (held[order[i]][p*lsdrs_pkg::DIGIT_W +: lsdrs_pkg::DIGIT_W] == d)
							next_order.push_back(order[i]);
				order = next_order;
			end
			foreach (order[i]) begin
				r.index = order[i][lsdrs_pkg::INDEX_W-1:0];
				r.key   = held[order[i]];
				r.last  = (i == order.size() - 1);
				pending.push_back(r);
			end
			held_count = 0;
		endfunction

		function void note_load(input logic [lsdrs_pkg::KEY_W-1:0] key, input logic last);
			if (held_count < lsdrs_pkg::MAX_ITEMS_DEF) begin
				held[held_count] = key;
				held_count++;
			end
			if (last)
				radix_ranks();
		endfunction

		task check_result(input logic [lsdrs_pkg::INDEX_W-1:0] index,
				input logic [lsdrs_pkg::KEY_W-1:0] key, input logic last);
			rank_t want;
			if (pending.size() == 0) begin
				report($sformatf("result idx %0d key %h with nothing pending", index, key));
				return;
			end
			want = pending.pop_front();
			if (index !== want.index)
				report($sformatf("item_index %0d, want %0d", index, want.index));
			if (key !== want.key)
				report($sformatf("sorted_key %h, want %h", key, want.key));
			if (last !== want.last)
				report($sformatf("end_of_run %b, want %b", last, want.last));
		endtask

		function int waiting();
			return pending.size();
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          load_valid = 1'b0;
	logic                          load_stall;
	logic [lsdrs_pkg::KEY_W-1:0]   sort_key = '0;
	logic                          last_item = 1'b0;
	logic                          result_valid;
	logic                          result_stall = 1'b0;
	logic [lsdrs_pkg::INDEX_W-1:0] item_index;
	logic [lsdrs_pkg::KEY_W-1:0]   sorted_key;
	logic                          end_of_run;

	rank_board sb = new();
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int holds_asked = 0;
	int holds_done = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	lsd_radix_sort_linked_buckets_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.load_valid(load_valid),
		.load_stall(load_stall),
		.sort_key(sort_key),
		.last_item(last_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.item_index(item_index),
		.sorted_key(sorted_key),
		.end_of_run(end_of_run)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (load_valid && !load_stall)
				sb.note_load(sort_key, last_item);
			if (result_valid && !result_stall)
				sb.check_result(item_index, sorted_key, end_of_run);
		end
	end

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else if (holds_done < holds_asked && result_valid) begin
			holds_done <= holds_done + 1;
			hold_left <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else
			result_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	always @(posedge clk) begin
		if ((load_valid && !load_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("lsd_radix_sort_linked_buckets_unit_tb: errors");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	task automatic send_load(input logic [lsdrs_pkg::KEY_W-1:0] key, input logic last);
		sort_key <= key;
		last_item <= last;
		load_valid <= 1'b1;
		do @(posedge clk); while (load_stall);
		if ($urandom_range(99) < tx_idle_pct) begin
			load_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
	endtask

	task automatic send_keys(input logic [lsdrs_pkg::KEY_W-1:0] keys[$]);
		foreach (keys[i])
			send_load(keys[i], i == keys.size() - 1);
	endtask

	// style 0: any key, 1: few repeated keys, 2: bytes from a narrow set
	task automatic send_set(input int len, input int style);
		logic [lsdrs_pkg::KEY_W-1:0] pool[4];
		logic [lsdrs_pkg::KEY_W-1:0] key;
		logic [7:0] byte_pick[4];
		foreach (pool[i])
			pool[i] = $urandom;
		for (int i = 0; i < len; i++) begin
			if (style == 0)
				key = $urandom;
			else if (style == 1)
				key = pool[$urandom_range(3)];
			else begin
				byte_pick[0] = 8'h00;
				byte_pick[1] = 8'hff;
				byte_pick[2] = 8'h80;
				byte_pick[3] = 8'($urandom_range(255));
				for (int b = 0; b < 4; b++)
					key[b*8 +: 8] = byte_pick[$urandom_range(3)];
			end
			send_load(key, i == len - 1);
		end
	endtask

	task automatic wait_drained();
		load_valid <= 1'b0;
		do @(posedge clk); while (sb.waiting() != 0);
	endtask

	initial begin
		logic [lsdrs_pkg::KEY_W-1:0] dk[$];
		int sent;
		int set_no;
		int len;
		int phase;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 11;
		rx_idle_pct = 76;
		dk = {32'h0000_0000};
		send_keys(dk);
		dk = {32'hffff_ffff, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h7fff_ffff};
		send_keys(dk);
		dk = {32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 32'h0000_0005};
		send_keys(dk);
		dk = {32'h0100_0000, 32'h0001_0000, 32'h0000_0100, 32'h0000_0001,
			32'h0100_0001, 32'h0001_0100};
		send_keys(dk);
		dk = {32'h1234_0000, 32'h0000_1234, 32'h1234_0000, 32'h0000_1234, 32'hffff_ffff};
		send_keys(dk);
		wait_drained();

		sent = 0;
		set_no = 0;
		phase = 0;
		while (sent < RAND_ITEMS) begin
			if (phase == 0 && sent >= RAND_ITEMS / 3) begin
				wait_drained();
				phase = 1;
				tx_idle_pct = 76;
				rx_idle_pct = 11;
			end else if (phase == 1 && sent >= 2 * RAND_ITEMS / 3) begin
				wait_drained();
				phase = 2;
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (set_no == 2)
				len = lsdrs_pkg::MAX_ITEMS_DEF;
			else if (set_no == 6)
				len = lsdrs_pkg::MAX_ITEMS_DEF + 2;
			else
				len = $urandom_range(1, 12);
			send_set(len, $urandom_range(2));
			if (set_no == 1)
				holds_asked++;
			sent += len;
			set_no++;
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.waiting() != 0)
			sb.report($sformatf("%0d results never arrived", sb.waiting()));
		if (sb.errors == 0)
			$display("lsd_radix_sort_linked_buckets_unit_tb: clean");
		else
			$display("lsd_radix_sort_linked_buckets_unit_tb: errors");
		$finish;
	end

endmodule
